// ===== hdl/tbs_pkg.sv =====
// tbs_pkg: types and constants shared by the bound smoothing block
// transaction structs, op and status codes, register indices, sequencer states
// no dependencies
package tbs_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] ST_ACK   = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  localparam logic [1:0] REG_MIN_DIST   = 2'd0;
  localparam logic [1:0] REG_MAX_SWEEPS = 2'd1;
  localparam logic [1:0] REG_SIZE       = 2'd2;

  localparam logic [7:0] SWEEPS_RESET = 8'd100;
  localparam logic [6:0] SIZE_RESET   = 7'd64;

  // six entries per triple, nine update steps
  localparam logic [2:0] LAST_ENTRY = 3'd5;
  localparam logic [3:0] LAST_STEP  = 4'd8;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  sweeps_done;
    logic [15:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic changed;
    logic fail;
  } step_flags_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_MIN_RD,
    S_MIN_CHK,
    S_SW_START,
    S_TR_RD,
    S_TR_LAST,
    S_STEP,
    S_TR_WR,
    S_SW_END
  } state_t;

endpackage

// ===== hdl/tbs_ram.sv =====
// tbs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tbs_tri_step.sv =====
// tbs_tri_step: one triangle update step on the six bounds of a triple
// depends on tbs_pkg
module tbs_tri_step import tbs_pkg::*; #(
  parameter int VW = 16
) (
  input  logic [5:0][VW-1:0] vals,
  input  logic [3:0]         step,
  output logic [5:0][VW-1:0] vals_out,
  output step_flags_t        flags
);

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VW] ? {VW{1'b1}} : s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_sub(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  logic [2:0]    t, lo, a, b;
  logic          upper, active;
  logic [VW-1:0] d;

  // entry order: uij uik ujk lji lki lkj
  always_comb begin
    t = 3'd0; lo = 3'd0; a = 3'd0; b = 3'd0; upper = 1'b0; active = 1'b1;
    unique case (step)
      4'd0: begin t = 3'd0; lo = 3'd3; a = 3'd1; b = 3'd2; upper = 1'b1; end
      4'd1: begin t = 3'd1; lo = 3'd4; a = 3'd0; b = 3'd2; upper = 1'b1; end
      4'd2: begin t = 3'd2; lo = 3'd5; a = 3'd0; b = 3'd1; upper = 1'b1; end
      4'd3: begin t = 3'd3; a = 3'd4; b = 3'd2; end
      4'd4: begin t = 3'd3; a = 3'd5; b = 3'd1; end
      4'd5: begin t = 3'd4; a = 3'd3; b = 3'd2; end
      4'd6: begin t = 3'd4; a = 3'd5; b = 3'd0; end
      4'd7: begin t = 3'd5; a = 3'd3; b = 3'd1; end
      4'd8: begin t = 3'd5; a = 3'd4; b = 3'd0; end
      default: active = 1'b0;
    endcase

    d = upper ? sat_add(vals[a], vals[b]) : sat_sub(vals[a], vals[b]);
    vals_out = vals;
    flags.changed = 1'b0;
    flags.fail = 1'b0;
    if (active) begin
      if (upper) begin
        if (vals[t] > d) begin
          vals_out[t] = d;
          flags.changed = 1'b1;
        end
        flags.fail = vals[lo] > d;
      end else if (vals[t] < d) begin
        vals_out[t] = d;
        flags.changed = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/triangle_bound_smoothing.sv =====
// triangle_bound_smoothing: top level, command port, sequencer and bound memory
// depends on tbs_pkg, tbs_ram, tbs_tri_step
//
// The bound matrix lives in one ram with a registered read. A load
// answers in the cycle after start; a read answers after the ram read
// and the S_RD_WAIT state. A run first walks every entry in use, then
// each sweep works through every triple i<j<k (six reads, up to nine
// update steps, six write-backs through the single ram port pair).
// busy stays high for the whole run. Each result shows for one cycle on
// out_strobe; the receiver cannot stall it. Stored entries have no reset;
// read only what was loaded.
module triangle_bound_smoothing import tbs_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = 2 * IW;
  localparam int VW = VALUE_BITS;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [5:0][VW-1:0] vals_r, vals_nxt;
  logic               cap_vld_r, cap_vld_nxt;
  logic [2:0]         cap_idx_r, cap_idx_nxt;
  logic [15:0]        chg_r, chg_nxt;
  logic [8:0]         sweep_r, sweep_nxt;
  logic [7:0]         left_r, left_nxt;
  logic               abort_r, abort_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [15:0]        md_r;
  logic [7:0]         maxsw_r;
  logic [6:0]         size_r;
  logic               strobe_r, strobe_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [15:0]        rdv_r, rdv_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [VW-1:0]      wdata, rdata;
  logic [5:0][VW-1:0] step_vals;
  step_flags_t        step_flags;
  logic [CW-1:0]      n;
  logic [VW-1:0]      md;
  logic               accept, in_range;
  logic [CW:0]        ie, je, ke, ne;

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return {r, c};
  endfunction

  function automatic logic [AW-1:0] tri_addr(input logic [2:0] e, input logic [IW-1:0] i,
                                             input logic [IW-1:0] j, input logic [IW-1:0] k);
    logic [AW-1:0] a;
    case (e)
      3'd0: a = {i, j};
      3'd1: a = {i, k};
      3'd2: a = {j, k};
      3'd3: a = {j, i};
      3'd4: a = {k, i};
      default: a = {k, j};
    endcase
    return a;
  endfunction

  tbs_ram #(.WIDTH(VW), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tbs_tri_step #(.VW(VW)) u_step (
    .vals     (vals_r),
    .step     (step_r),
    .vals_out (step_vals),
    .flags    (step_flags)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_range  = (int'(in_item.row) < MAX_POINTS) && (int'(in_item.col) < MAX_POINTS);
  assign n         = (int'(size_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(size_r);
  assign md        = VW'(md_r);
  assign ie        = {1'b0, i_r};
  assign je        = {1'b0, j_r};
  assign ke        = {1'b0, k_r};
  assign ne        = {1'b0, n};

  assign out_strobe           = strobe_r;
  assign out_item.status      = status_r;
  assign out_item.sweeps_done = sweep_r;
  assign out_item.read_value  = rdv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r    <= '0;
      maxsw_r <= SWEEPS_RESET;
      size_r  <= SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_DIST:   md_r    <= cfg_data;
        REG_MAX_SWEEPS: maxsw_r <= cfg_data[7:0];
        REG_SIZE:       size_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cap_vld_r <= 1'b0;
      chg_r     <= '0;
      sweep_r   <= '0;
      strobe_r  <= 1'b0;
      abort_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cap_vld_r <= cap_vld_nxt;
      chg_r     <= chg_nxt;
      sweep_r   <= sweep_nxt;
      strobe_r  <= strobe_nxt;
      abort_r   <= abort_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    step_r    <= step_nxt;
    vals_r    <= vals_nxt;
    cap_idx_r <= cap_idx_nxt;
    left_r    <= left_nxt;
    rd_ok_r   <= rd_ok_nxt;
    status_r  <= status_nxt;
    rdv_r     <= rdv_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    step_nxt    = step_r;
    vals_nxt    = vals_r;
    cap_vld_nxt = 1'b0;
    cap_idx_nxt = cap_idx_r;
    chg_nxt     = chg_r;
    sweep_nxt   = sweep_r;
    left_nxt    = left_r;
    abort_nxt   = abort_r;
    rd_ok_nxt   = rd_ok_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    rdv_nxt     = rdv_r;
    we          = 1'b0;
    waddr       = addr(IW'(in_item.row), IW'(in_item.col));
    wdata       = VW'(in_item.value);
    raddr       = addr(IW'(in_item.row), IW'(in_item.col));

    // reads of a triple land in the cycle after issue
    if (cap_vld_r) begin
      vals_nxt[cap_idx_r] = rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.op)
            OP_LOAD: begin
              we         = in_range;
              strobe_nxt = 1'b1;
              status_nxt = ST_ACK;
              rdv_nxt    = '0;
            end
            OP_RUN: begin
              i_nxt     = '0;
              j_nxt     = '0;
              left_nxt  = maxsw_r;
              sweep_nxt = '0;
              abort_nxt = 1'b0;
              state_nxt = (n == '0) ? S_SW_START : S_MIN_RD;
            end
            OP_READ: begin
              rd_ok_nxt = in_range;
              state_nxt = S_RD_WAIT;
            end
            default: begin
              strobe_nxt = 1'b1;
              status_nxt = ST_ACK;
              rdv_nxt    = '0;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        strobe_nxt = 1'b1;
        status_nxt = ST_ACK;
        rdv_nxt    = rd_ok_r ? 16'(rdata) : '0;
        state_nxt  = S_IDLE;
      end
      S_MIN_RD: begin
        raddr = addr(i_r[IW-1:0], j_r[IW-1:0]);
        if (i_r != j_r) begin
          state_nxt = S_MIN_CHK;
        end else if (je + 1'b1 < ne) begin
          j_nxt = j_r + 1'b1;
        end else if (ie + 1'b1 < ne) begin
          i_nxt = i_r + 1'b1;
          j_nxt = '0;
        end else begin
          state_nxt = S_SW_START;
        end
      end
      S_MIN_CHK: begin
        waddr = addr(i_r[IW-1:0], j_r[IW-1:0]);
        wdata = md;
        we    = (rdata < md);
        state_nxt = S_MIN_RD;
        if (je + 1'b1 < ne) begin
          j_nxt = j_r + 1'b1;
        end else if (ie + 1'b1 < ne) begin
          i_nxt = i_r + 1'b1;
          j_nxt = '0;
        end else begin
          state_nxt = S_SW_START;
        end
      end
      S_SW_START: begin
        sweep_nxt = sweep_r + 1'b1;
        chg_nxt   = '0;
        i_nxt     = CW'(0);
        j_nxt     = CW'(1);
        k_nxt     = CW'(2);
        cnt_nxt   = '0;
        state_nxt = (ne < 3) ? S_SW_END : S_TR_RD;
      end
      S_TR_RD: begin
        raddr       = tri_addr(cnt_r, i_r[IW-1:0], j_r[IW-1:0], k_r[IW-1:0]);
        cap_vld_nxt = 1'b1;
        cap_idx_nxt = cnt_r;
        if (cnt_r == LAST_ENTRY) begin
          state_nxt = S_TR_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_TR_LAST: begin
        step_nxt  = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        vals_nxt = step_vals;
        if (step_flags.changed && chg_r != 16'hFFFF) begin
          chg_nxt = chg_r + 1'b1;
        end
        cnt_nxt = '0;
        if (step_flags.fail) begin
          abort_nxt = 1'b1;
          state_nxt = S_TR_WR;
        end else if (step_r == LAST_STEP) begin
          state_nxt = S_TR_WR;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_TR_WR: begin
        we    = 1'b1;
        waddr = tri_addr(cnt_r, i_r[IW-1:0], j_r[IW-1:0], k_r[IW-1:0]);
        wdata = vals_r[cnt_r];
        if (cnt_r != LAST_ENTRY) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cnt_nxt = '0;
          if (abort_r) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_ERR;
            rdv_nxt    = '0;
            state_nxt  = S_IDLE;
          end else if (ke + 1'b1 < ne) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_TR_RD;
          end else if (je + 2'd2 < ne) begin
            j_nxt     = j_r + 1'b1;
            k_nxt     = j_r + 2'd2;
            state_nxt = S_TR_RD;
          end else if (ie + 2'd3 < ne) begin
            i_nxt     = i_r + 1'b1;
            j_nxt     = i_r + 2'd2;
            k_nxt     = i_r + 2'd3;
            state_nxt = S_TR_RD;
          end else begin
            state_nxt = S_SW_END;
          end
        end
      end
      S_SW_END: begin
        if (chg_r == '0) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_CONV;
          rdv_nxt    = '0;
          state_nxt  = S_IDLE;
        end else if (left_r == '0) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_LIMIT;
          rdv_nxt    = '0;
          state_nxt  = S_IDLE;
        end else begin
          left_nxt  = left_r - 1'b1;
          state_nxt = S_SW_START;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a load answers in the cycle after it is accepted
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.op == OP_LOAD) |=> (out_strobe && out_item.status == ST_ACK))
    else $error("load transaction not acknowledged");

  // a read holds busy while in S_RD_WAIT, then answers with busy low
  a_read_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.op == OP_READ) |=> busy ##1 (out_strobe && !busy))
    else $error("read transaction timing wrong");

  // a run never answers with the plain acknowledge code
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(state_r) != S_IDLE && $past(state_r) != S_RD_WAIT)
      |-> out_item.status != ST_ACK)
    else $error("run finished with acknowledge status");

  // sweep count stays at most one above the max-sweeps register while a run is going
  a_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != S_RD_WAIT) |-> sweep_r <= ({1'b0, maxsw_r} + 9'd1))
    else $error("sweep count beyond limit");

endmodule
